[hw/rtl/fip_pkg.sv]
// ----------------------------------------------------------------------------
// fip_pkg
// Shared constants and the binary64 rounding/packing function used by the
// multiplier and the reciprocal unit.
// ----------------------------------------------------------------------------
package fip_pkg;

  localparam int unsigned ExponentBits = 32;

  localparam logic [63:0] BitsOne     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] BitsNanDflt = 64'hFFF8_0000_0000_0000;
  localparam logic [10:0] ExpAllOnes  = 11'h7FF;
  localparam logic [63:0] QuietBit    = 64'h0008_0000_0000_0000;

  // Rounds a significand with its leading one at bit 105 (or smaller, when
  // the value is far below the subnormal range) and a biased exponent to a
  // binary64 pattern, round to nearest even, with gradual underflow.
  function automatic logic [63:0] fip_round(input logic sign,
                                            input logic signed [13:0] e,
                                            input logic [105:0] p);
    logic [6:0]        sh;
    logic [211:0]      ext;
    logic [10:0]       ef;
    logic [52:0]       m;
    logic              g;
    logic              s;
    logic              inc;
    logic [62:0]       body;
    logic signed [13:0] one_minus;
    logic [63:0]       res;
    one_minus = 14'sd1 - e;
    if (e >= 14'sd1) begin
      sh = 7'd0;
      ef = e[10:0];
    end else begin
      ef = '0;
      if (one_minus > 14'sd127) sh = 7'd127;
      else sh = one_minus[6:0];
    end
    ext  = {p, 106'b0} >> sh;
    m    = ext[211:159];
    g    = ext[158];
    s    = |ext[157:0];
    inc  = g & (s | m[0]);
    // A carry out of the fraction moves naturally into the exponent field.
    body = {ef, m[51:0]} + {62'b0, inc};
    if (e >= 14'sd2047) res = {sign, ExpAllOnes, 52'b0};
    else res = {sign, body};
    return res;
  endfunction

endpackage

[hw/rtl/fip_fmul.sv]
// ----------------------------------------------------------------------------
// fip_fmul
// Multi-cycle binary64 multiplier: four 27x27 partial products, a one-bit
// per cycle normalizer and a rounding stage.
// ----------------------------------------------------------------------------
module fip_fmul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);
  import fip_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_PP   = 4'b0010,
    M_NORM = 4'b0100,
    M_RND  = 4'b1000
  } mul_state_e;

  mul_state_e state_q, state_d;

  logic [52:0]        ma_q, mb_q;
  logic               sign_q;
  logic signed [13:0] e_q;
  logic [105:0]       p_q;
  logic [53:0]        pp_q;
  logic [1:0]         psh_q;
  logic [2:0]         cnt_q;
  logic               done_q;
  logic [63:0]        res_q;

  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn, special;
  logic [63:0] spec_res;
  logic [26:0] opa, opb;
  logic [1:0]  psh_d;
  logic [105:0] pp_shift;

  assign ea     = a_i[62:52];
  assign eb     = b_i[62:52];
  assign fa     = a_i[51:0];
  assign fb     = b_i[51:0];
  assign a_nan  = (ea == ExpAllOnes) && (fa != '0);
  assign b_nan  = (eb == ExpAllOnes) && (fb != '0);
  assign a_inf  = (ea == ExpAllOnes) && (fa == '0);
  assign b_inf  = (eb == ExpAllOnes) && (fb == '0);
  assign a_zero = (a_i[62:0] == '0);
  assign b_zero = (b_i[62:0] == '0);
  assign sgn    = a_i[63] ^ b_i[63];
  assign special = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;

  always_comb begin
    priority if (a_nan) spec_res = a_i | QuietBit;
    else if (b_nan) spec_res = b_i | QuietBit;
    else if ((a_inf && b_zero) || (b_inf && a_zero)) spec_res = BitsNanDflt;
    else if (a_inf || b_inf) spec_res = {sgn, ExpAllOnes, 52'b0};
    else spec_res = {sgn, 63'b0};
  end

  // Partial product selection; the high halves are 26 bits wide.
  always_comb begin
    unique case (cnt_q)
      3'd0: begin
        opa = ma_q[26:0]; opb = mb_q[26:0]; psh_d = 2'd0;
      end
      3'd1: begin
        opa = ma_q[26:0]; opb = {1'b0, mb_q[52:27]}; psh_d = 2'd1;
      end
      3'd2: begin
        opa = {1'b0, ma_q[52:27]}; opb = mb_q[26:0]; psh_d = 2'd1;
      end
      default: begin
        opa = {1'b0, ma_q[52:27]}; opb = {1'b0, mb_q[52:27]}; psh_d = 2'd2;
      end
    endcase
  end

  always_comb begin
    unique case (psh_q)
      2'd0:    pp_shift = {52'b0, pp_q};
      2'd1:    pp_shift = {25'b0, pp_q, 27'b0};
      default: pp_shift = {pp_q[51:0], 54'b0};
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE: if (go_i && !special) state_d = M_PP;
      M_PP:   if (cnt_q == 3'd4) state_d = M_NORM;
      M_NORM: if (p_q[105] || (e_q <= -14'sd64)) state_d = M_RND;
      M_RND:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          cnt_q <= '0;
          if (go_i && special) done_q <= 1'b1;
        end
        M_PP:   cnt_q <= cnt_q + 3'd1;
        M_NORM: ;
        M_RND:  done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      M_IDLE: begin
        if (go_i) begin
          res_q  <= spec_res;
          sign_q <= sgn;
          ma_q   <= {(ea != '0), fa};
          mb_q   <= {(eb != '0), fb};
          e_q    <= 14'(signed'({3'b0, (ea == '0) ? 11'd1 : ea}))
                  + 14'(signed'({3'b0, (eb == '0) ? 11'd1 : eb})) - 14'sd1022;
          p_q    <= '0;
        end
      end
      M_PP: begin
        if (cnt_q != 3'd4) begin
          pp_q  <= opa * opb;
          psh_q <= psh_d;
        end
        if (cnt_q != 3'd0) p_q <= p_q + pp_shift;
      end
      M_NORM: begin
        if (!p_q[105] && (e_q > -14'sd64)) begin
          p_q <= {p_q[104:0], 1'b0};
          e_q <= e_q - 14'sd1;
        end
      end
      M_RND: res_q <= fip_round(sign_q, e_q, p_q);
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/fip_frecip.sv]
// ----------------------------------------------------------------------------
// fip_frecip
// Correctly rounded binary64 reciprocal by restoring division, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module fip_frecip (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [63:0] res_o
);
  import fip_pkg::*;

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_NORM = 4'b0010,
    R_DIV  = 4'b0100,
    R_RND  = 4'b1000
  } rcp_state_e;

  rcp_state_e state_q, state_d;

  logic [52:0]        m_q;
  logic signed [13:0] e_q;
  logic               sign_q;
  logic [54:0]        r_q;
  logic [54:0]        q_q;
  logic [5:0]         cnt_q;
  logic               done_q;
  logic [63:0]        res_q;

  logic [10:0]  ex;
  logic [51:0]  fx;
  logic         x_nan, x_inf, x_zero, special;
  logic [63:0]  spec_res;
  logic         ge;
  logic [54:0]  r_sub;
  logic         rnz;
  logic [105:0] p_fin;
  logic signed [13:0] e_fin;

  assign ex      = x_i[62:52];
  assign fx      = x_i[51:0];
  assign x_nan   = (ex == ExpAllOnes) && (fx != '0);
  assign x_inf   = (ex == ExpAllOnes) && (fx == '0);
  assign x_zero  = (x_i[62:0] == '0);
  assign special = x_nan | x_inf | x_zero;

  always_comb begin
    priority if (x_nan) spec_res = x_i | QuietBit;
    else if (x_inf) spec_res = {x_i[63], 63'b0};
    else spec_res = {x_i[63], ExpAllOnes, 52'b0};
  end

  assign ge    = (r_q >= {2'b0, m_q});
  assign r_sub = ge ? (r_q - {2'b0, m_q}) : r_q;
  assign rnz   = (r_q != '0);

  // An exact power of two gives a quotient with its integer bit set.
  always_comb begin
    if (q_q[54]) begin
      p_fin = {q_q[54:2], q_q[1], 51'b0, q_q[0] | rnz};
      e_fin = 14'sd2046 - e_q;
    end else begin
      p_fin = {q_q[53:1], q_q[0], 51'b0, rnz};
      e_fin = 14'sd2045 - e_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      R_IDLE: if (go_i && !special) state_d = R_NORM;
      R_NORM: if (m_q[52]) state_d = R_DIV;
      R_DIV:  if (cnt_q == 6'd54) state_d = R_RND;
      R_RND:  state_d = R_IDLE;
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        R_IDLE: if (go_i && special) done_q <= 1'b1;
        R_NORM: cnt_q <= '0;
        R_DIV:  cnt_q <= cnt_q + 6'd1;
        R_RND:  done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      R_IDLE: begin
        if (go_i) begin
          res_q  <= spec_res;
          sign_q <= x_i[63];
          m_q    <= {(ex != '0), fx};
          e_q    <= 14'(signed'({3'b0, (ex == '0) ? 11'd1 : ex}));
        end
      end
      R_NORM: begin
        if (m_q[52]) begin
          r_q <= 55'd1 << 52;
          q_q <= '0;
        end else begin
          m_q <= {m_q[51:0], 1'b0};
          e_q <= e_q - 14'sd1;
        end
      end
      R_DIV: begin
        q_q <= {q_q[53:0], ge};
        r_q <= {r_sub[53:0], 1'b0};
      end
      R_RND: res_q <= fip_round(sign_q, e_fin, p_fin);
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/float_integer_power.sv]
// A zero exponent goes from S_IDLE straight to S_DONE; otherwise the block runs
// up to two multiplies per exponent bit, plus the reciprocal first when the
// exponent is negative. It takes one item at a time, and all multiplies share
// the single multiplier. Reset clears the sequencer and both arithmetic units;
// done_o pulses for one cycle per result and the receiver cannot stall it.
// ----------------------------------------------------------------------------
// float_integer_power
// Binary64 base raised to a signed integer power by iterative squaring on a
// shared multi-cycle multiplier.
// ----------------------------------------------------------------------------
module float_integer_power (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [63:0]                           base_bits_i,
  input  logic signed [fip_pkg::ExponentBits-1:0] exponent_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  output logic [63:0]                           result_bits_o
);
  import fip_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RECIP = 5'b00010,
    S_STEP  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } seq_state_e;

  typedef enum logic [1:0] {
    DST_ACC,
    DST_X,
    DST_RES
  } dst_e;

  seq_state_e state_q;
  dst_e       dst_q;
  logic [63:0] x_q, acc_q, res_q;
  logic [ExponentBits-1:0] mag_q;
  logic        odd_done_q;

  logic        accept;
  logic [ExponentBits-1:0] neg_mag;
  logic        mul_go, mul_done, rcp_go, rcp_done;
  logic [63:0] mul_a, mul_b, mul_res, rcp_res;

  assign accept  = start_i && !busy_o;
  assign neg_mag = ~exponent_i + ExponentBits'(1);
  assign rcp_go  = accept && (exponent_i != '0) && exponent_i[ExponentBits-1];
  assign mul_go  = (state_q == S_STEP);
  assign mul_a   = x_q;
  assign mul_b   = ((mag_q > 1) && !(mag_q[0] && !odd_done_q)) ? x_q : acc_q;

  fip_fmul u_fmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  fip_frecip u_frecip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (rcp_go),
    .x_i    (base_bits_i),
    .done_o (rcp_done),
    .res_o  (rcp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      dst_q      <= DST_ACC;
      odd_done_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            odd_done_q <= 1'b0;
            if (exponent_i == '0) state_q <= S_DONE;
            else if (exponent_i[ExponentBits-1]) state_q <= S_RECIP;
            else state_q <= S_STEP;
          end
        end
        S_RECIP: if (rcp_done) state_q <= S_STEP;
        S_STEP: begin
          // An odd bit folds x into the accumulator before the squaring.
          if (mag_q > 1) begin
            if (mag_q[0] && !odd_done_q) begin
              dst_q      <= DST_ACC;
              odd_done_q <= 1'b1;
            end else begin
              dst_q <= DST_X;
            end
          end else begin
            dst_q <= DST_RES;
          end
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            if (dst_q == DST_X) odd_done_q <= 1'b0;
            state_q <= (dst_q == DST_RES) ? S_DONE : S_STEP;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          acc_q <= BitsOne;
          res_q <= BitsOne;
          x_q   <= base_bits_i;
          mag_q <= exponent_i[ExponentBits-1] ? neg_mag : exponent_i;
        end
      end
      S_RECIP: if (rcp_done) x_q <= rcp_res;
      S_WAIT: begin
        if (mul_done) begin
          unique case (dst_q)
            DST_ACC: acc_q <= mul_res;
            DST_X: begin
              x_q   <= mul_res;
              mag_q <= mag_q >> 1;
            end
            default: res_q <= mul_res;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign result_bits_o = res_q;

  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_zero_exp_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && exponent_i == '0) |=> (done_o && result_bits_o == BitsOne))
    else $error("zero exponent did not give one");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && rcp_done))
    else $error("both arithmetic units finished together");

  a_mag_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (mag_q != '0))
    else $error("exponent magnitude lost");

endmodule

[verif/float_integer_power_tb.sv]
// ----------------------------------------------------------------------------
// float_integer_power_tb
// Drives binary64 bases and signed exponents through the command interface and
// checks every result against a bit-exact software model of the power loop.
// ----------------------------------------------------------------------------
module float_integer_power_tb;
  import fip_pkg::*;

  localparam logic [63:0] SignBit  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] InfBits  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] MinNorm  = 64'h0010_0000_0000_0000;
  localparam int          WatchLimit = 20000;
  localparam int          NumRandom  = 1530;

  // Rounds z * 2^s (plus a sticky bit below z) to a binary64 pattern.
  function automatic logic [63:0] round_pack(logic sgn, logic [191:0] z, int s, logic st);
    int k;
    int be;
    int q;
    logic [191:0] mant;
    logic [191:0] mask;
    logic g;
    logic stk;
    logic [63:0] body;
    k = 0;
    for (int i = 191; i >= 0; i--) begin
      if (z[i]) begin
        k = i;
        break;
      end
    end
    be = k + s + 1023;
    q = (be >= 1) ? k - 52 : -1074 - s;
    if (be >= 2047) return {sgn, 63'b0} | InfBits;
    mant = (q >= 0) ? (z >> q) : (z << (-q));
    g = (q >= 1 && q - 1 <= 191) ? z[q-1] : 1'b0;
    if (q - 1 <= 0) mask = '0;
    else if (q - 1 >= 192) mask = '1;
    else mask = (192'b1 << (q - 1)) - 192'b1;
    stk = st | (|(z & mask));
    body = (be >= 1 ? (64'(be - 1) << 52) : 64'b0) + 64'(mant[52:0]) + 64'(g & (stk | mant[0]));
    if (body >= InfBits) body = InfBits;
    return {sgn, body[62:0]};
  endfunction

  function automatic logic is_nan(logic [63:0] x);
    return x[62:52] == ExpAllOnes && x[51:0] != 0;
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
    logic sgn;
    logic [52:0] ma;
    logic [52:0] mb;
    int ea;
    int eb;
    sgn = a[63] ^ b[63];
    if (is_nan(a)) return a | QuietBit;
    if (is_nan(b)) return b | QuietBit;
    if (a[62:52] == ExpAllOnes || b[62:52] == ExpAllOnes) begin
      if (a[62:0] == 0 || b[62:0] == 0) return BitsNanDflt;
      return {sgn, 63'b0} | InfBits;
    end
    if (a[62:0] == 0 || b[62:0] == 0) return {sgn, 63'b0};
    ma = {a[62:52] != 0, a[51:0]};
    mb = {b[62:52] != 0, b[51:0]};
    ea = (a[62:52] == 0) ? 1 : int'(a[62:52]);
    eb = (b[62:52] == 0) ? 1 : int'(b[62:52]);
    return round_pack(sgn, 192'(ma) * 192'(mb), ea + eb - 2150, 1'b0);
  endfunction

  function automatic logic [63:0] frecip(logic [63:0] x);
    logic [255:0] num;
    logic [255:0] quo;
    logic [255:0] rem;
    logic [52:0] m;
    int e;
    if (is_nan(x)) return x | QuietBit;
    if (x[62:52] == ExpAllOnes) return {x[63], 63'b0};
    if (x[62:0] == 0) return {x[63], 63'b0} | InfBits;
    m = {x[62:52] != 0, x[51:0]};
    e = (x[62:52] == 0) ? 1 : int'(x[62:52]);
    num = 256'b1 << 160;
    quo = num / 256'(m);
    rem = num % 256'(m);
    return round_pack(x[63], quo[191:0], 915 - e, rem != 0);
  endfunction

  function automatic logic [63:0] int_power(logic [63:0] base, logic signed [31:0] ex);
    logic [31:0] mag;
    logic [63:0] x;
    logic [63:0] acc;
    if (ex == 0) return BitsOne;
    if (ex < 0) begin
      mag = -ex;
      x = frecip(base);
    end else begin
      mag = ex;
      x = base;
    end
    acc = BitsOne;
    while (mag > 1) begin
      if (mag[0]) acc = fmul(x, acc);
      x = fmul(x, x);
      mag = mag >> 1;
    end
    return fmul(x, acc);
  endfunction

  class power_scoreboard;
    logic [63:0] pending[$];

    function void note_transfer(logic [63:0] base, logic signed [31:0] ex);
      pending.push_back(int_power(base, ex));
    endfunction

    // Returns an empty string when the result matches the oldest prediction.
    function string check_result(logic [63:0] got);
      logic [63:0] want;
      if (pending.size() == 0) return $sformatf("unexpected result %h", got);
      want = pending.pop_front();
      if (got !== want) return $sformatf("result_bits %h, predicted %h", got, want);
      return "";
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic [63:0]        base_bits_i;
  logic signed [31:0] exponent_i;
  logic               busy_o;
  logic               done_o;
  logic [63:0]        result_bits_o;

  power_scoreboard sb;
  int  mismatches;
  int  results_seen;
  int  idle_cycles;
  int  items_sent;
  logic in_transfer;

  float_integer_power dut (
    .clk_i, .rst_ni, .start_i, .base_bits_i, .exponent_i, .busy_o, .done_o, .result_bits_o
  );

  always #4 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && done_o) begin
      msg = sb.check_result(result_bits_o);
      results_seen++;
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_transfer || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Timeout after %0d cycles without a transfer", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  assign in_transfer = rst_ni && start_i && !busy_o;

  // Holds one item on the inputs until the block takes it.
  task automatic send(logic [63:0] base, logic signed [31:0] ex, bit may_idle);
    @(negedge clk_i);
    if (may_idle && $urandom_range(99) < 6) begin
      start_i = 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk_i);
    end
    start_i = 1'b1;
    base_bits_i = base;
    exponent_i = ex;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    sb.note_transfer(base, ex);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] random_base();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: b[62:52] = 11'(1023 + $urandom_range(1, 0) - 1);
      4:          b[62:52] = '0;
      5:          b[62:52] = ExpAllOnes;
      6:          b[62:0] = $urandom_range(1) ? 63'b0 : 63'(InfBits);
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic signed [31:0] random_exponent();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $signed($urandom_range(80)) - 40;
      5, 6:          return $signed($urandom_range(4000)) - 2000;
      default:       return $urandom;
    endcase
  endfunction

  initial begin
    logic [63:0] bases[13];
    logic signed [31:0] exps[13];
    sb = new();
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    base_bits_i = '0;
    exponent_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero exponent on NaN and infinity, zero bases under negative powers,
    // the most negative and most positive exponents, subnormals and extremes.
    bases = '{64'h7FF8_0000_0000_0001, InfBits, 64'h0, SignBit, SignBit, BitsOne,
              BitsOne | SignBit, 64'h1, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFF0_0000_0000_0000,
              64'h7FF0_0000_0000_0001, MinNorm, 64'hFFFF_FFFF_FFFF_FFFF};
    exps  = '{0, 0, -1, -3, -2, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 2,
              -5, 3, 32'sh8000_0000, 1};
    foreach (bases[i]) send(bases[i], exps[i], 1'b0);
    send(64'h4000_0000_0000_0000, 1023, 1'b0);
    send(64'h4000_0000_0000_0000, 1024, 1'b0);
    send(64'h4000_0000_0000_0000, -1074, 1'b0);
    send(64'h4000_0000_0000_0000, -1075, 1'b0);
    send(64'h3FF0_0000_0000_0001, 32'sh7FFF_FFFF, 1'b0);
    send(64'h3FEF_FFFF_FFFF_FFFF, 32'sh8000_0000, 1'b0);
    send(64'h0, 0, 1'b0);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 200) drain();
      send(random_base(), random_exponent(), !(n >= 400 && n < 800));
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d items and checked %0d results, covering special bases,",
             items_sent, results_seen);
    $display("subnormals, zero and extreme exponents, with random sender pauses.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
